@@ src/earliest_free_worker_scheduler_defines.svh @@
// Assertion helpers for the scheduler.
`ifndef EARLIEST_FREE_WORKER_SCHEDULER_DEFINES_SVH
`define EARLIEST_FREE_WORKER_SCHEDULER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define EFWS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define EFWS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/efws_pkg.sv @@
`default_nettype none

package efws_pkg;

  localparam int DEFAULT_MAX_WORKERS = 16;
  localparam int RESET_WORKERS       = 16;
  localparam int COUNT_IN_W          = 5;
  localparam int HEAP_CAP            = 31;  // largest count a 5-bit write can ask for
  localparam int WORKER_W            = 5;   // holds any id below HEAP_CAP
  localparam int DUR_W               = 32;
  localparam int TIME_W              = 64;
  localparam int OUT_ID_W            = 4;

  typedef struct packed {
    logic [TIME_W-1:0]   free_time;
    logic [WORKER_W-1:0] worker;
  } heap_entry_t;

  // key order: free time first, lower worker id wins a tie
  function automatic logic key_less(input heap_entry_t a, input heap_entry_t b);
    key_less = (a.free_time < b.free_time) ||
               ((a.free_time == b.free_time) && (a.worker < b.worker));
  endfunction

endpackage

`default_nettype wire

@@ src/efws_heap_ram.sv @@
`default_nettype none

module efws_heap_ram import efws_pkg::*; #(
  parameter int DEPTH = DEFAULT_MAX_WORKERS,
  parameter int AW    = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        clr,
  input  wire logic        wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire heap_entry_t wr_data,
  input  wire logic        rd_en,
  input  wire logic [AW-1:0] rd_addr_a,
  input  wire logic [AW-1:0] rd_addr_b,
  output heap_entry_t      rd_data_a,
  output heap_entry_t      rd_data_b
);

  heap_entry_t         mem_r [DEPTH];
  logic [DEPTH-1:0]    vld_r;
  heap_entry_t         rd_ent_a_r, rd_ent_b_r;
  logic                rd_vld_a_r, rd_vld_b_r;
  logic [AW-1:0]       rd_addr_a_r, rd_addr_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_ent_a_r  <= mem_r[rd_addr_a];
      rd_ent_b_r  <= mem_r[rd_addr_b];
      rd_vld_a_r  <= vld_r[rd_addr_a];
      rd_vld_b_r  <= vld_r[rd_addr_b];
      rd_addr_a_r <= rd_addr_a;
      rd_addr_b_r <= rd_addr_b;
    end
  end

  // unwritten entry reads as its restart value
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    rd_data_a = rd_vld_a_r ? rd_ent_a_r
                           : heap_entry_t'{free_time: '0, worker: WORKER_W'(rd_addr_a_r)};
    rd_data_b = rd_vld_b_r ? rd_ent_b_r
                           : heap_entry_t'{free_time: '0, worker: WORKER_W'(rd_addr_b_r)};
  end

endmodule

`default_nettype wire

@@ src/earliest_free_worker_scheduler.sv @@
// The result word is registered at the edge that accepts the job.
// A new job is taken only once any sift of the last one has finished and no output
//   word is held by out_stall; a zero duration needs no sift. The job rate is set
//   by the single key comparator, used twice per level, and the heap RAM read.
// Reset (rst_n, synchronous, active low): 16 workers (fewer if MAX_WORKERS is
//   smaller), every free time zero, heap entry k holds worker k; no clearing pass.
`default_nettype none

`include "earliest_free_worker_scheduler_defines.svh"

module earliest_free_worker_scheduler import efws_pkg::*; #(
  parameter int MAX_WORKERS = DEFAULT_MAX_WORKERS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // job input
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [DUR_W-1:0]      in_duration,
  // assignment output
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [OUT_ID_W-1:0]        out_worker,
  output logic [TIME_W-1:0]          out_start_time,
  // worker count register
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [COUNT_IN_W-1:0] cfg_worker_count
);

  // A write can never ask for more than HEAP_CAP workers, so the heap never
  // needs more entries than that, whatever MAX_WORKERS is.
  localparam int DEPTH     = (MAX_WORKERS < HEAP_CAP) ? MAX_WORKERS : HEAP_CAP;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int RST_COUNT = (DEPTH < RESET_WORKERS) ? DEPTH : RESET_WORKERS;
  localparam int CIW       = AW + 2;  // child index width, holds 2*pos+2

  localparam logic [COUNT_IN_W-1:0] DEPTH_C = COUNT_IN_W'(DEPTH);

  // sequencer codes
  localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for a job
  localparam logic [1:0] ST_READ  = 2'd1;  // fetch both children of pos
  localparam logic [1:0] ST_PICK  = 2'd2;  // smaller child
  localparam logic [1:0] ST_PLACE = 2'd3;  // child against the sinking entry

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  heap_entry_t   root_r, root_nxt;     // heap position 0 lives in flops
  heap_entry_t   cur_r, cur_nxt;       // entry being sifted down
  heap_entry_t   best_r, best_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [OUT_ID_W-1:0] out_id_r, out_id_nxt;
  logic [TIME_W-1:0]   out_time_r, out_time_nxt;

  logic                in_accept, cfg_write;
  logic                sift_needed;
  logic [TIME_W:0]     sum_w;
  logic [TIME_W-1:0]   next_time;
  logic [AW+3:0]       root_id_ext;
  logic [CIW-1:0]      left_ext, right_ext, count_ext;
  logic                has_left, has_right;
  logic [COUNT_IN_W-1:0] cnt_in;

  // shared key comparator
  heap_entry_t   cmp_a, cmp_b;
  logic          cmp_less;

  // heap RAM ports
  heap_entry_t   rd_left, rd_right, wr_data;
  logic          ram_wr, place_now;

  // ---------------------------------------------------------------------------
  // Handshakes. A pending config word blocks jobs, so the two never meet.
  // ---------------------------------------------------------------------------
  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;

  assign out_valid      = out_valid_r;
  assign out_worker     = out_id_r;
  assign out_start_time = out_time_r;

  // ---------------------------------------------------------------------------
  // Root update: saturating add of the duration. No sift when the key is
  // unchanged (zero duration, or free time already at the top).
  // ---------------------------------------------------------------------------
  assign sum_w       = {1'b0, root_r.free_time} + (TIME_W + 1)'(in_duration);
  assign next_time   = sum_w[TIME_W] ? '1 : sum_w[TIME_W-1:0];
  assign sift_needed = (in_duration != '0) && (root_r.free_time != '1);
  assign root_id_ext = {4'b0, root_r.worker[AW-1:0]};

  // children of pos: 2*pos+1 and 2*pos+2, in range below the worker count
  assign left_ext  = CIW'({pos_r, 1'b1});
  assign right_ext = left_ext + CIW'(1);
  assign count_ext = CIW'(count_r);
  assign has_left  = left_ext < count_ext;
  assign has_right = right_ext < count_ext;

  // clamp the written count to 1..DEPTH
  always_comb begin
    if (cfg_worker_count == '0) begin
      cnt_in = COUNT_IN_W'(1);
    end else if (cfg_worker_count > DEPTH_C) begin
      cnt_in = DEPTH_C;
    end else begin
      cnt_in = cfg_worker_count;
    end
  end

  // one comparator: right vs left while picking, child vs sinking entry after
  always_comb begin
    if (state_r == ST_PICK) begin
      cmp_a = rd_right;
      cmp_b = rd_left;
    end else begin
      cmp_a = best_r;
      cmp_b = cur_r;
    end
    cmp_less = key_less(cmp_a, cmp_b);
  end

  // Hole-style sift: a smaller child moves up into pos; the sinking entry is
  // written once, where it comes to rest.
  assign place_now = ((state_r == ST_READ) && !has_left) || (state_r == ST_PLACE);
  assign wr_data   = ((state_r == ST_PLACE) && cmp_less) ? best_r : cur_r;
  assign ram_wr    = place_now && (pos_r != '0);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    best_idx_nxt  = best_idx_r;
    count_nxt     = count_r;
    root_nxt      = root_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r;
    out_id_nxt    = out_id_r;
    out_time_nxt  = out_time_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (place_now && (pos_r == '0)) begin
      root_nxt = wr_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (cfg_write) begin
          count_nxt = CW'(cnt_in);
          root_nxt  = '{free_time: '0, worker: '0};
        end else if (in_accept) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = root_id_ext[OUT_ID_W-1:0];
          out_time_nxt  = root_r.free_time;
          if (sift_needed) begin
            cur_nxt   = '{free_time: next_time, worker: root_r.worker};
            pos_nxt   = '0;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = has_left ? ST_PICK : ST_IDLE;
      end
      ST_PICK: begin
        if (has_right && cmp_less) begin
          best_nxt     = rd_right;
          best_idx_nxt = right_ext[AW-1:0];
        end else begin
          best_nxt     = rd_left;
          best_idx_nxt = left_ext[AW-1:0];
        end
        state_nxt = ST_PLACE;
      end
      ST_PLACE: begin
        if (cmp_less) begin
          pos_nxt   = best_idx_r;
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= CW'(RST_COUNT);
      root_r      <= '{free_time: '0, worker: '0};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      root_r      <= root_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    best_idx_r <= best_idx_nxt;
    cur_r      <= cur_nxt;
    best_r     <= best_nxt;
    out_id_r   <= out_id_nxt;
    out_time_r <= out_time_nxt;
  end

  // positions 1 and up; position 0 is root_r
  efws_heap_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_heap_ram (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (cfg_write),
    .wr_en     (ram_wr),
    .wr_addr   (pos_r),
    .wr_data   (wr_data),
    .rd_en     ((state_r == ST_READ) && has_left),
    .rd_addr_a (left_ext[AW-1:0]),
    .rd_addr_b (right_ext[AW-1:0]),
    .rd_data_a (rd_left),
    .rd_data_b (rd_right)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `EFWS_ASSERT_NXT(a_sift_starts, clk, rst_n, in_accept && sift_needed,
    state_r == ST_READ, "changed root key did not start a sift")
  `EFWS_ASSERT_NXT(a_root_kept, clk, rst_n, in_accept && !sift_needed,
    $stable(root_r) && (state_r == ST_IDLE), "unchanged key disturbed the heap")
  `EFWS_ASSERT_NXT(a_pos_descends, clk, rst_n, (state_r == ST_PLACE) && cmp_less,
    pos_r > $past(pos_r), "sift position did not move down")
  `EFWS_ASSERT_IMP(a_pick_has_child, clk, rst_n, state_r == ST_PICK,
    has_left && (count_r != '0), "picking a child of a leaf")

endmodule

`default_nettype wire
